/* sv/assert_macros.svh */
// assertion macros shared by the collision test block
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
`define PST_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define PST_ASSERT(label, clk, rst, prop)
`define PST_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

/* sv/pst_pkg.sv */
// types and constants of the polygon separating-axis collision test
// used by every module of the block but the vertex store; no dependencies
package pst_pkg;

   typedef enum logic [1:0] {
      MODE_VTX_A   = 2'd0,
      MODE_VTX_B   = 2'd1,
      MODE_POS_A   = 2'd2,
      MODE_COMPUTE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK  = 2'd0,
      STATUS_FEW = 2'd1,
      STATUS_OVF = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EDGE_I,
      ST_EDGE_J,
      ST_EDGE_DIFF,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_SUM,
      ST_SQRT_WAIT,
      ST_DIV_X,
      ST_DIV_Y,
      ST_PROJ_RD,
      ST_PROJ_MX,
      ST_PROJ_MY,
      ST_PROJ_ACC,
      ST_EVAL,
      ST_FLIP_X,
      ST_FLIP_Y,
      ST_FLIP_C,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   localparam int          MIN_VERTS  = 3;
   localparam int          DIV_W      = 46;
   localparam int          UNIT_SHIFT = 14;
   localparam logic [50:0] ROUND_HALF = 51'd8192;
   localparam logic [30:0] DEPTH_MAX  = 31'h7fff_ffff;

endpackage

/* sv/pst_vertex_mem.sv */
// vertex store of one polygon: one write port, one registered read port
// no package dependencies
module pst_vertex_mem #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [63:0]              wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [63:0]              rd_data
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pst_isqrt.sv */
// iterative integer square root, two radicand bits per cycle
// depends on pst_pkg for the unit status struct
module pst_isqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [63:0]            radicand,
   output pst_pkg::unit_stat_type stat,
   output logic [31:0]            root
);

   logic [63:0] v_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [63:0] trial;
   logic        take;

   assign trial = res_ff + bit_ff;
   assign take  = (v_ff >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         res_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (take) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = res_ff[31:0];

endmodule

/* sv/pst_divider.sv */
// restoring divider, one quotient bit per cycle
// depends on pst_pkg for the dividend width and unit status struct
module pst_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pst_pkg::DIV_W-1:0]     dividend,
   input  logic [31:0]                   divisor,
   output pst_pkg::unit_stat_type        stat,
   output logic [pst_pkg::DIV_W-1:0]     quotient
);

   localparam int DW = pst_pkg::DIV_W;

   logic [DW-1:0] quo_ff;
   logic [31:0]   rem_ff;
   logic [31:0]   den_ff;
   logic [5:0]    cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [32:0]   trial;
   logic [32:0]   diff;
   logic          ge;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign ge    = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[31:0] : trial[31:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

/* sv/polygon_separating_axis_test_top.sv */
// separating-axis collision test of two convex polygons
// request channel (req_): mode 0/1 appends a vertex to the first/second polygon, mode 2 sets
// the first body position, mode 3 carries the second body position and starts the test.
// loading transfers are taken one per cycle while no test is running and give no response.
// response channel (rsp_): one transfer per mode 3 request: colliding flag, Q16.16 depth,
// Q2.14 axis of least overlap pointing from the first body to the second, and a status.
// a mode 3 request with an overflowed store or too few vertices answers without running the test.
// otherwise each edge runs a 32-step square root, two 46-step divisions, then a walk
// over both vertex memories with one read and two multiplies per vertex; a zero-length
// edge skips these steps. the final flip points the axis from the first body to the
// second and rounds the depth; a separating axis ends the walk at once.
// requests are taken only while no test is running.
// the result sits in an output register; a stalled receiver holds it, and the next test
// waits at its end until that register is free; no requests are taken meanwhile.
// reset clears both vertex counts, the overflow flag and the first body position.
// depends on pst_pkg, pst_vertex_mem, pst_isqrt, pst_divider, assert_macros.svh
`include "assert_macros.svh"
module polygon_separating_axis_test_top #(
   parameter int MAX_VERTICES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_colliding,
   output logic [30:0]        rsp_penetration_depth,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic [1:0]         rsp_status
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int DW = pst_pkg::DIV_W;

   pst_pkg::state_type state_ff, state_in;

   logic [CW-1:0] cnt0_ff, cnt1_ff;
   logic          ovf_ff;
   logic signed [31:0] fpx_ff, fpy_ff, spx_ff, spy_ff;
   logic          p_ff, q_ff;
   logic [IW-1:0] i_ff, k_ff;
   logic signed [31:0] vix_ff, viy_ff, yl_ff;
   logic          sx_ff, sy_ff;
   logic [30:0]   ma_ff, mb_ff;
   logic [61:0]   sqa_ff, sqb_ff;
   logic [31:0]   len_ff;
   logic signed [15:0] nx_ff, ny_ff, bnx_ff, bny_ff;
   logic signed [48:0] pa_ff, pb_ff;
   logic signed [48:0] mina_ff, maxa_ff, minb_ff, maxb_ff;
   logic          found_ff;
   logic signed [49:0] best_ff;
   logic          res_col_ff;
   logic [30:0]   res_depth_ff;
   logic signed [15:0] res_nx_ff, res_ny_ff;
   logic [1:0]    res_st_ff;
   logic          rsp_valid_ff;
   logic          rsp_col_ff;
   logic [30:0]   rsp_depth_ff;
   logic signed [15:0] rsp_nx_ff, rsp_ny_ff;
   logic [1:0]    rsp_st_ff;

   logic req_fire, out_free;
   logic wr0, wr1;
   logic [IW-1:0] rd_addr;
   logic [63:0] rd0, rd1, rdp, rdq;
   logic [CW-1:0] n_p, n_q, i_next, k_next;
   logic [IW-1:0] j_idx;
   logic signed [32:0] ax, ay;
   logic [32:0] ma33, mb33, ma1, mb1, ma2, mb2;
   logic edge_zero, edge_last, proj_last;
   logic sqrt_start, div_start;
   logic [63:0] sq_sum;
   logic [DW-1:0] div_num;
   logic [31:0] div_den;
   pst_pkg::unit_stat_type sqrt_stat, div_stat;
   logic [31:0] sqrt_root;
   logic [DW-1:0] div_quo;
   logic signed [15:0] q_mag, q_signed;
   logic signed [32:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [48:0] mul_p, proj_d;
   logic separated;
   logic signed [49:0] ov1, ov2, ov, dot;
   logic [50:0] rnd;
   logic [36:0] dd;

   assign req_ready = (state_ff == pst_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // vertex stores
   assign wr0 = req_fire && (req_mode == pst_pkg::MODE_VTX_A) &&
                (cnt0_ff < CW'(MAX_VERTICES));
   assign wr1 = req_fire && (req_mode == pst_pkg::MODE_VTX_B) &&
                (cnt1_ff < CW'(MAX_VERTICES));

   pst_vertex_mem #(.DEPTH(MAX_VERTICES)) u_mem_a (
      .clock(clock), .wr_en(wr0), .wr_addr(cnt0_ff[IW-1:0]),
      .wr_data({req_coord_y, req_coord_x}), .rd_addr(rd_addr), .rd_data(rd0)
   );
   pst_vertex_mem #(.DEPTH(MAX_VERTICES)) u_mem_b (
      .clock(clock), .wr_en(wr1), .wr_addr(cnt1_ff[IW-1:0]),
      .wr_data({req_coord_y, req_coord_x}), .rd_addr(rd_addr), .rd_data(rd1)
   );

   assign rdp = p_ff ? rd1 : rd0;
   assign rdq = q_ff ? rd1 : rd0;
   assign n_p = p_ff ? cnt1_ff : cnt0_ff;
   assign n_q = q_ff ? cnt1_ff : cnt0_ff;

   assign i_next    = CW'(i_ff) + CW'(1);
   assign k_next    = CW'(k_ff) + CW'(1);
   assign j_idx     = (i_next < n_p) ? i_next[IW-1:0] : '0;
   assign edge_last = (i_next == n_p);
   assign proj_last = (k_next == n_q);

   // edge normal (-ey, ex) and magnitude scaling below 2^31
   assign ax = 33'(viy_ff) - 33'($signed(rdp[63:32]));
   assign ay = 33'($signed(rdp[31:0])) - 33'(vix_ff);
   assign edge_zero = (ax == '0) && (ay == '0);
   assign ma33 = ax[32] ? 33'(-ax) : 33'(ax);
   assign mb33 = ay[32] ? 33'(-ay) : 33'(ay);
   assign ma1  = (|(ma33[32:31] | mb33[32:31])) ? (ma33 >> 1) : ma33;
   assign mb1  = (|(ma33[32:31] | mb33[32:31])) ? (mb33 >> 1) : mb33;
   assign ma2  = (|(ma1[32:31] | mb1[32:31])) ? (ma1 >> 1) : ma1;
   assign mb2  = (|(ma1[32:31] | mb1[32:31])) ? (mb1 >> 1) : mb1;

   assign sq_sum = 64'(sqa_ff) + 64'(sqb_ff);

   pst_isqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .radicand(sq_sum),
      .stat(sqrt_stat), .root(sqrt_root)
   );

   pst_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .stat(div_stat), .quotient(div_quo)
   );

   // rounded quotient, sign restored per component
   assign q_mag    = {1'b0, div_quo[14:0]};
   assign q_signed = ((state_ff == pst_pkg::ST_DIV_X) ? sx_ff : sy_ff) ? -q_mag : q_mag;

   // shared projection / flip multiplier
   always_comb begin
      mul_a = 33'(spx_ff) - 33'(fpx_ff);
      mul_b = bnx_ff;
      unique case (state_ff)
         pst_pkg::ST_PROJ_MX: begin
            mul_a = 33'($signed(rdq[31:0]));
            mul_b = nx_ff;
         end
         pst_pkg::ST_PROJ_MY: begin
            mul_a = 33'(yl_ff);
            mul_b = ny_ff;
         end
         pst_pkg::ST_FLIP_Y: begin
            mul_a = 33'(spy_ff) - 33'(fpy_ff);
            mul_b = bny_ff;
         end
         default: begin
         end
      endcase
   end
   assign mul_p  = 49'(mul_a) * 49'(mul_b);
   assign proj_d = pa_ff + pb_ff;

   assign separated = (mina_ff >= maxb_ff) || (minb_ff >= maxa_ff);
   assign ov1 = 50'(maxa_ff) - 50'(minb_ff);
   assign ov2 = 50'(maxb_ff) - 50'(mina_ff);
   assign ov  = (ov2 < ov1) ? ov2 : ov1;
   assign dot = 50'(pa_ff) + 50'(pb_ff);
   assign rnd = {1'b0, best_ff} + pst_pkg::ROUND_HALF;
   assign dd  = rnd[50:14];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      rd_addr    = k_ff;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      div_num    = {1'b0, ma_ff, 14'd0} + DW'(sqrt_root >> 1);
      div_den    = sqrt_root;
      unique case (state_ff)
         pst_pkg::ST_IDLE: begin
            if (req_fire && (req_mode == pst_pkg::MODE_COMPUTE)) begin
               if (ovf_ff || (cnt0_ff < CW'(pst_pkg::MIN_VERTS)) ||
                   (cnt1_ff < CW'(pst_pkg::MIN_VERTS))) begin
                  state_in = pst_pkg::ST_DONE;
               end else begin
                  state_in = pst_pkg::ST_EDGE_I;
               end
            end
         end
         pst_pkg::ST_EDGE_I: begin
            rd_addr  = i_ff;
            state_in = pst_pkg::ST_EDGE_J;
         end
         pst_pkg::ST_EDGE_J: begin
            rd_addr  = j_idx;
            state_in = pst_pkg::ST_EDGE_DIFF;
         end
         pst_pkg::ST_EDGE_DIFF: begin
            if (!edge_zero) begin
               state_in = pst_pkg::ST_SQ_X;
            end else if (edge_last && p_ff) begin
               state_in = pst_pkg::ST_FLIP_X;
            end else begin
               state_in = pst_pkg::ST_EDGE_I;
            end
         end
         pst_pkg::ST_SQ_X:  state_in = pst_pkg::ST_SQ_Y;
         pst_pkg::ST_SQ_Y:  state_in = pst_pkg::ST_SQ_SUM;
         pst_pkg::ST_SQ_SUM: begin
            sqrt_start = 1'b1;
            state_in   = pst_pkg::ST_SQRT_WAIT;
         end
         pst_pkg::ST_SQRT_WAIT: begin
            if (sqrt_stat.done) begin
               div_start = 1'b1;
               state_in  = pst_pkg::ST_DIV_X;
            end
         end
         pst_pkg::ST_DIV_X: begin
            div_num = {1'b0, mb_ff, 14'd0} + DW'(len_ff >> 1);
            div_den = len_ff;
            if (div_stat.done) begin
               div_start = 1'b1;
               state_in  = pst_pkg::ST_DIV_Y;
            end
         end
         pst_pkg::ST_DIV_Y: begin
            if (div_stat.done) begin
               state_in = pst_pkg::ST_PROJ_RD;
            end
         end
         pst_pkg::ST_PROJ_RD: state_in = pst_pkg::ST_PROJ_MX;
         pst_pkg::ST_PROJ_MX: state_in = pst_pkg::ST_PROJ_MY;
         pst_pkg::ST_PROJ_MY: state_in = pst_pkg::ST_PROJ_ACC;
         pst_pkg::ST_PROJ_ACC: begin
            if (proj_last && q_ff) begin
               state_in = pst_pkg::ST_EVAL;
            end else begin
               state_in = pst_pkg::ST_PROJ_RD;
            end
         end
         pst_pkg::ST_EVAL: begin
            if (separated) begin
               state_in = pst_pkg::ST_DONE;
            end else if (edge_last && p_ff) begin
               state_in = pst_pkg::ST_FLIP_X;
            end else begin
               state_in = pst_pkg::ST_EDGE_I;
            end
         end
         pst_pkg::ST_FLIP_X: begin
            state_in = found_ff ? pst_pkg::ST_FLIP_Y : pst_pkg::ST_DONE;
         end
         pst_pkg::ST_FLIP_Y: state_in = pst_pkg::ST_FLIP_C;
         pst_pkg::ST_FLIP_C: state_in = pst_pkg::ST_DONE;
         pst_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = pst_pkg::ST_IDLE;
            end
         end
         default: state_in = pst_pkg::ST_IDLE;
      endcase
   end

   // load bookkeeping and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt0_ff      <= '0;
         cnt1_ff      <= '0;
         ovf_ff       <= 1'b0;
         fpx_ff       <= '0;
         fpy_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == pst_pkg::ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            case (req_mode)
               pst_pkg::MODE_VTX_A: begin
                  if (wr0) cnt0_ff <= cnt0_ff + CW'(1);
                  else     ovf_ff  <= 1'b1;
               end
               pst_pkg::MODE_VTX_B: begin
                  if (wr1) cnt1_ff <= cnt1_ff + CW'(1);
                  else     ovf_ff  <= 1'b1;
               end
               pst_pkg::MODE_POS_A: begin
                  fpx_ff <= req_coord_x;
                  fpy_ff <= req_coord_y;
               end
               default: begin
               end
            endcase
         end else if ((state_ff == pst_pkg::ST_DONE) && out_free) begin
            cnt0_ff <= '0;
            cnt1_ff <= '0;
            ovf_ff  <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         pst_pkg::ST_IDLE: begin
            spx_ff       <= req_coord_x;
            spy_ff       <= req_coord_y;
            p_ff         <= 1'b0;
            i_ff         <= '0;
            found_ff     <= 1'b0;
            res_col_ff   <= 1'b0;
            res_depth_ff <= '0;
            res_nx_ff    <= '0;
            res_ny_ff    <= '0;
            if (ovf_ff) begin
               res_st_ff <= pst_pkg::STATUS_OVF;
            end else if ((cnt0_ff < CW'(pst_pkg::MIN_VERTS)) ||
                         (cnt1_ff < CW'(pst_pkg::MIN_VERTS))) begin
               res_st_ff <= pst_pkg::STATUS_FEW;
            end else begin
               res_st_ff <= pst_pkg::STATUS_OK;
            end
         end
         pst_pkg::ST_EDGE_J: begin
            vix_ff <= $signed(rdp[31:0]);
            viy_ff <= $signed(rdp[63:32]);
         end
         pst_pkg::ST_EDGE_DIFF: begin
            sx_ff <= ax[32];
            sy_ff <= ay[32];
            ma_ff <= ma2[30:0];
            mb_ff <= mb2[30:0];
            if (edge_zero) begin
               if (edge_last) begin
                  p_ff <= 1'b1;
                  i_ff <= '0;
               end else begin
                  i_ff <= i_next[IW-1:0];
               end
            end
         end
         pst_pkg::ST_SQ_X: sqa_ff <= 62'(ma_ff) * 62'(ma_ff);
         pst_pkg::ST_SQ_Y: sqb_ff <= 62'(mb_ff) * 62'(mb_ff);
         pst_pkg::ST_SQRT_WAIT: begin
            if (sqrt_stat.done) len_ff <= sqrt_root;
         end
         pst_pkg::ST_DIV_X: begin
            if (div_stat.done) nx_ff <= q_signed;
         end
         pst_pkg::ST_DIV_Y: begin
            if (div_stat.done) begin
               ny_ff <= q_signed;
               q_ff  <= 1'b0;
               k_ff  <= '0;
            end
         end
         pst_pkg::ST_PROJ_MX: begin
            pa_ff <= mul_p;
            yl_ff <= $signed(rdq[63:32]);
         end
         pst_pkg::ST_PROJ_MY: pb_ff <= mul_p;
         pst_pkg::ST_PROJ_ACC: begin
            if (!q_ff) begin
               if ((k_ff == '0) || (proj_d < mina_ff)) mina_ff <= proj_d;
               if ((k_ff == '0) || (proj_d > maxa_ff)) maxa_ff <= proj_d;
            end else begin
               if ((k_ff == '0) || (proj_d < minb_ff)) minb_ff <= proj_d;
               if ((k_ff == '0) || (proj_d > maxb_ff)) maxb_ff <= proj_d;
            end
            if (proj_last) begin
               q_ff <= 1'b1;
               k_ff <= '0;
            end else begin
               k_ff <= k_next[IW-1:0];
            end
         end
         pst_pkg::ST_EVAL: begin
            if (!separated) begin
               if (!found_ff || (ov < best_ff)) begin
                  found_ff <= 1'b1;
                  best_ff  <= ov;
                  bnx_ff   <= nx_ff;
                  bny_ff   <= ny_ff;
               end
               if (edge_last) begin
                  p_ff <= 1'b1;
                  i_ff <= '0;
               end else begin
                  i_ff <= i_next[IW-1:0];
               end
            end
         end
         pst_pkg::ST_FLIP_X: begin
            pa_ff      <= mul_p;
            res_col_ff <= 1'b1;
            if (!found_ff) res_depth_ff <= pst_pkg::DEPTH_MAX;
         end
         pst_pkg::ST_FLIP_Y: pb_ff <= mul_p;
         pst_pkg::ST_FLIP_C: begin
            res_depth_ff <= (|dd[36:31]) ? pst_pkg::DEPTH_MAX : dd[30:0];
            res_nx_ff    <= dot[49] ? -bnx_ff : bnx_ff;
            res_ny_ff    <= dot[49] ? -bny_ff : bny_ff;
         end
         pst_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_col_ff   <= res_col_ff;
               rsp_depth_ff <= res_depth_ff;
               rsp_nx_ff    <= res_nx_ff;
               rsp_ny_ff    <= res_ny_ff;
               rsp_st_ff    <= res_st_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_colliding         = rsp_col_ff;
   assign rsp_penetration_depth = rsp_depth_ff;
   assign rsp_normal_x          = rsp_nx_ff;
   assign rsp_normal_y          = rsp_ny_ff;
   assign rsp_status            = rsp_st_ff;

   `PST_ASSERT(a_compute_blocks, clock, reset, req_fire && (req_mode == pst_pkg::MODE_COMPUTE) |=> !req_ready)
   `PST_ASSERT(a_counts_cleared, clock, reset, (state_ff == pst_pkg::ST_DONE) && out_free |=> (cnt0_ff == '0) && (cnt1_ff == '0) && !ovf_ff && rsp_valid)
   `PST_ASSERT_NEVER(a_error_not_colliding, clock, reset, rsp_valid && (rsp_status != pst_pkg::STATUS_OK) && rsp_colliding)

endmodule
